FILE: rtl/lalf_pkg.sv
// Shared types, constants and helper functions of the level alert ladder filter.
// Depends on nothing; every other file of the block imports it.
package lalf_pkg;

   localparam int HistoryDepth = 5;
   localparam int DistW = 13;
   localparam int LevelW = 14;
   localparam int ThrW = 7;

   localparam logic [1:0] EV_THRESHOLD = 2'd0;
   localparam logic [1:0] EV_REFILL = 2'd1;
   localparam logic [1:0] EV_FAULT = 2'd2;
   localparam logic [1:0] EV_RECOVER = 2'd3;

   localparam logic [1:0] REG_FULL = 2'd0;
   localparam logic [1:0] REG_EMPTY = 2'd1;
   localparam logic [1:0] REG_REFILL = 2'd2;
   localparam logic [1:0] REG_LIMIT = 2'd3;

   localparam logic [13:0] LEVEL_FULL = 14'd10000;
   localparam logic signed [7:0] LADDER_NONE = -8'sd10;
   localparam logic [15:0] THIRD_RECIP = 16'd43691;

   typedef struct packed {
      logic             sample_valid;
      logic [DistW-1:0] distance_mm;
   } item_type;

   typedef struct packed {
      logic [15:0] full_distance_tenths;
      logic [15:0] empty_distance_tenths;
      logic [13:0] refill_delta;
      logic [7:0]  fault_limit;
   } cfg_type;

   typedef struct packed {
      logic [1:0]        event_kind;
      logic [ThrW-1:0]   threshold_level;
      logic [LevelW-1:0] level_hundredths;
      logic [DistW-1:0]  event_distance;
      logic              last_event;
   } event_type;

   function automatic logic signed [7:0] ladder_from(input logic [13:0] p);
      logic [3:0] n;
      n = 4'd0;
      for (int k = 1; k < 10; k++) begin
         if (p > 14'(k * 1000)) n = n + 4'd1;
      end
      if (p == 14'd0) return LADDER_NONE;
      return $signed({1'b0, 7'(n) * 7'd10});
   endfunction

   function automatic logic thr_hit(input logic signed [7:0] n, input logic [13:0] fl);
      return (n >= 8'sd0) && (fl <= 14'(n[6:0]) * 14'd100);
   endfunction

endpackage

FILE: rtl/lalf_front.sv
// Front end of the level alert ladder filter: accepts sample items into a
// two-entry queue that the back end drains. Depends on lalf_pkg.
module lalf_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  lalf_pkg::item_type in_item,
   output logic              q_valid,
   output lalf_pkg::item_type q_item,
   input  logic              q_pop
);
   import lalf_pkg::*;

   item_type   slot_ff [2];
   logic       rd_ff, rd_in, wr_ff, wr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;

   assign in_ready = cnt_ff != 2'd2;
   assign push = in_valid && in_ready;
   assign q_valid = cnt_ff != 2'd0;
   assign q_item = slot_ff[rd_ff];

   always_comb begin
      rd_in = rd_ff ^ q_pop;
      wr_in = wr_ff ^ push;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ff] <= in_item;
      if (reset) begin
         rd_ff <= 1'b0;
         wr_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         rd_ff <= rd_in;
         wr_ff <= wr_in;
         cnt_ff <= cnt_in;
      end
   end
endmodule

FILE: rtl/lalf_div.sv
// Restoring divider, one quotient bit a cycle, for the level map.
// Depends on lalf_pkg only for house consistency of imports.
module lalf_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [29:0] dividend,
   input  logic [15:0] divisor,
   output logic        done,
   output logic [13:0] quotient
);
   import lalf_pkg::*;

   logic [29:0] q_ff, q_in;
   logic [15:0] rem_ff, rem_in;
   logic [15:0] dvs_ff, dvs_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [16:0] trial;

   assign done = done_ff;
   assign quotient = q_ff[13:0];
   assign trial = {rem_ff, q_ff[29]};

   always_comb begin
      q_in = q_ff;
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         q_in = dividend;
         rem_in = 16'd0;
         dvs_in = divisor;
         cnt_in = 5'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = 16'(trial - {1'b0, dvs_ff});
            q_in = {q_ff[28:0], 1'b1};
         end else begin
            rem_in = trial[15:0];
            q_in = {q_ff[28:0], 1'b0};
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd29) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end
endmodule

FILE: rtl/lalf_back.sv
// Back end of the level alert ladder filter: sequences one sample through
// fault counting, level map, history filter and alert ladder. Uses lalf_div.
module lalf_back (
   input  logic                clock,
   input  logic                reset,
   input  lalf_pkg::cfg_type   cfg,
   input  logic                q_valid,
   input  lalf_pkg::item_type  q_item,
   output logic                q_pop,
   output logic                ev_valid,
   output lalf_pkg::event_type ev,
   input  logic                ev_ready
);
   import lalf_pkg::*;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_DISPATCH = 4'd1;
   localparam logic [3:0] S_FAULT = 4'd2;
   localparam logic [3:0] S_MAP = 4'd3;
   localparam logic [3:0] S_MAPD = 4'd4;
   localparam logic [3:0] S_MAPW = 4'd5;
   localparam logic [3:0] S_HIST = 4'd6;
   localparam logic [3:0] S_SUM = 4'd7;
   localparam logic [3:0] S_FD = 4'd8;
   localparam logic [3:0] S_DECIDE = 4'd9;
   localparam logic [3:0] S_REFILL = 4'd10;
   localparam logic [3:0] S_LOOP = 4'd11;
   localparam logic [3:0] S_RECOVER = 4'd12;

   logic [3:0]        state_ff, state_in;
   item_type          item_ff, item_in;
   logic [7:0]        fcnt_ff, fcnt_in;
   logic              fault_ff, fault_in;
   logic              recov_ff, recov_in;
   logic [DistW-1:0]  hist_ff [HistoryDepth];
   logic [2:0]        ptr_ff, ptr_in, fill_ff, fill_in;
   logic              hist_we;
   logic              armed_ff, armed_in;
   logic [LevelW-1:0] prev_ff, prev_in, cur_lvl_ff, cur_lvl_in, fl_ff, fl_in;
   logic [DistW-1:0]  cur_dist_ff, cur_dist_in, fd_ff, fd_in, map_d_ff, map_d_in;
   logic              phase_ff, phase_in;
   logic signed [7:0] next_ff, next_in;
   logic [29:0]       prod_ff, prod_in;
   logic              ev_valid_ff, ev_valid_in;
   event_type         ev_ff, ev_in;

   logic        out_free, div_start, div_done;
   logic [13:0] div_q, map_lvl;
   logic [16:0] d10;
   logic [15:0] span, sum;
   logic [DistW-1:0] mn, mx, rd;
   logic [7:0]  fcnt_inc;
   logic        map_trivial;
   logic [14:0] tri_sum;

   lalf_div u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend(prod_ff + 30'(span >> 1)), .divisor(span),
      .done(div_done), .quotient(div_q)
   );

   assign ev_valid = ev_valid_ff;
   assign ev = ev_ff;
   assign out_free = !ev_valid_ff || ev_ready;
   assign q_pop = (state_ff == S_IDLE) && q_valid;
   assign d10 = 17'(map_d_ff) * 17'd10;
   assign span = cfg.empty_distance_tenths - cfg.full_distance_tenths;
   assign fcnt_inc = (fcnt_ff == 8'd255) ? fcnt_ff : fcnt_ff + 8'd1;
   assign rd = (fd_ff != '0) ? fd_ff : cur_dist_ff;

   always_comb begin
      map_trivial = 1'b1;
      map_lvl = 14'd0;
      if (d10 >= {1'b0, cfg.empty_distance_tenths}) begin
         map_lvl = 14'd0;
      end else if (d10 <= {1'b0, cfg.full_distance_tenths}) begin
         map_lvl = LEVEL_FULL;
      end else begin
         map_trivial = 1'b0;
      end
   end

   always_comb begin
      sum = 16'd0;
      mn = hist_ff[0];
      mx = hist_ff[0];
      for (int i = 0; i < HistoryDepth; i++) begin
         sum = sum + 16'(hist_ff[i]);
         if (hist_ff[i] < mn) mn = hist_ff[i];
         if (hist_ff[i] > mx) mx = hist_ff[i];
      end
      tri_sum = 15'(sum - 16'(mn) - 16'(mx) + 16'd1);
   end

   always_comb begin
      state_in = state_ff;
      item_in = item_ff;
      fcnt_in = fcnt_ff;
      fault_in = fault_ff;
      recov_in = recov_ff;
      ptr_in = ptr_ff;
      fill_in = fill_ff;
      hist_we = 1'b0;
      armed_in = armed_ff;
      prev_in = prev_ff;
      cur_lvl_in = cur_lvl_ff;
      fl_in = fl_ff;
      cur_dist_in = cur_dist_ff;
      fd_in = fd_ff;
      map_d_in = map_d_ff;
      phase_in = phase_ff;
      next_in = next_ff;
      prod_in = prod_ff;
      div_start = 1'b0;
      ev_valid_in = ev_valid_ff && !ev_ready;
      ev_in = ev_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               item_in = q_item;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            if (!item_ff.sample_valid) begin
               fcnt_in = fcnt_inc;
               if (fcnt_inc >= cfg.fault_limit && !fault_ff) begin
                  fault_in = 1'b1;
                  state_in = S_FAULT;
               end else begin
                  state_in = S_IDLE;
               end
            end else begin
               recov_in = fault_ff;
               fault_in = 1'b0;
               fcnt_in = 8'd0;
               cur_dist_in = item_ff.distance_mm;
               map_d_in = item_ff.distance_mm;
               phase_in = 1'b0;
               state_in = S_MAP;
            end
         end
         S_FAULT: begin
            if (out_free) begin
               ev_valid_in = 1'b1;
               ev_in = '{EV_FAULT, 7'd0, cur_lvl_ff, cur_dist_ff, 1'b1};
               state_in = S_IDLE;
            end
         end
         S_MAP: begin
            prod_in = 30'(16'(cfg.empty_distance_tenths - d10[15:0])) * 30'd10000;
            if (map_trivial) begin
               if (phase_ff) begin
                  fl_in = map_lvl;
                  state_in = S_DECIDE;
               end else begin
                  cur_lvl_in = map_lvl;
                  state_in = S_HIST;
               end
            end else begin
               state_in = S_MAPD;
            end
         end
         S_MAPD: begin
            div_start = 1'b1;
            state_in = S_MAPW;
         end
         S_MAPW: begin
            if (div_done) begin
               if (phase_ff) begin
                  fl_in = div_q;
                  state_in = S_DECIDE;
               end else begin
                  cur_lvl_in = div_q;
                  state_in = S_HIST;
               end
            end
         end
         S_HIST: begin
            hist_we = 1'b1;
            ptr_in = (ptr_ff == 3'(HistoryDepth - 1)) ? 3'd0 : ptr_ff + 3'd1;
            if (fill_ff < 3'(HistoryDepth)) fill_in = fill_ff + 3'd1;
            state_in = (fill_ff >= 3'(HistoryDepth - 1)) ? S_SUM : S_RECOVER;
         end
         S_SUM: begin
            prod_in = 30'(tri_sum) * 30'(THIRD_RECIP);
            state_in = S_FD;
         end
         S_FD: begin
            fd_in = prod_ff[29:17];
            map_d_in = prod_ff[29:17];
            phase_in = 1'b1;
            state_in = S_MAP;
         end
         S_DECIDE: begin
            prev_in = fl_ff;
            if (!armed_ff) begin
               armed_in = 1'b1;
               next_in = ladder_from(fl_ff);
               state_in = S_RECOVER;
            end else if ({1'b0, fl_ff} >= {1'b0, prev_ff} + {1'b0, cfg.refill_delta}) begin
               next_in = ladder_from(fl_ff);
               state_in = S_REFILL;
            end else begin
               state_in = S_LOOP;
            end
         end
         S_REFILL: begin
            if (out_free) begin
               ev_valid_in = 1'b1;
               ev_in = '{EV_REFILL, 7'd0, fl_ff, rd,
                         !thr_hit(next_ff, fl_ff) && !recov_ff};
               state_in = S_LOOP;
            end
         end
         S_LOOP: begin
            if (!thr_hit(next_ff, fl_ff)) begin
               state_in = S_RECOVER;
            end else if (out_free) begin
               ev_valid_in = 1'b1;
               ev_in = '{EV_THRESHOLD, next_ff[6:0], fl_ff, rd,
                         !thr_hit(next_ff - 8'sd10, fl_ff) && !recov_ff};
               next_in = next_ff - 8'sd10;
            end
         end
         S_RECOVER: begin
            if (!recov_ff) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               ev_valid_in = 1'b1;
               ev_in = '{EV_RECOVER, 7'd0, cur_lvl_ff, cur_dist_ff, 1'b1};
               recov_in = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      map_d_ff <= map_d_in;
      phase_ff <= phase_in;
      prod_ff <= prod_in;
      fl_ff <= fl_in;
      fd_ff <= fd_in;
      ev_ff <= ev_in;
      if (reset) begin
         state_ff <= S_IDLE;
         fcnt_ff <= 8'd0;
         fault_ff <= 1'b0;
         recov_ff <= 1'b0;
         for (int i = 0; i < HistoryDepth; i++) hist_ff[i] <= '0;
         ptr_ff <= 3'd0;
         fill_ff <= 3'd0;
         armed_ff <= 1'b0;
         prev_ff <= '0;
         next_ff <= LADDER_NONE;
         cur_lvl_ff <= '0;
         cur_dist_ff <= '0;
         ev_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         fcnt_ff <= fcnt_in;
         fault_ff <= fault_in;
         recov_ff <= recov_in;
         if (hist_we) hist_ff[ptr_ff] <= cur_dist_ff;
         ptr_ff <= ptr_in;
         fill_ff <= fill_in;
         armed_ff <= armed_in;
         prev_ff <= prev_in;
         next_ff <= next_in;
         cur_lvl_ff <= cur_lvl_in;
         cur_dist_ff <= cur_dist_in;
         ev_valid_ff <= ev_valid_in;
      end
   end
endmodule

FILE: rtl/level_alert_ladder_filter_top.sv
// Top level of the level alert ladder filter: configuration registers, front
// queue and back sequencer. Depends on lalf_pkg, lalf_front and lalf_back.
// A good sample is mapped to a level once, and again from the filtered distance with a
// full history; each mapping that falls between the full and empty distances runs the
// serial divider.
// The back end takes one sample at a time and accepts no new one until it has issued its events.
// Reset is synchronous and active high; it restores register defaults and
// clears all filter state, with no clearing pass.
module level_alert_ladder_filter_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // sample_valid, distance_mm
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // threshold_level, level_hundredths, event_distance
   output logic [1:0]  rsp_tuser,   // event_kind
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [15:0] csr_wdata
);
   import lalf_pkg::*;

   cfg_type   cfg_ff;
   item_type  in_item, q_item;
   logic      q_valid, q_pop;
   event_type ev;

   assign in_item = '{req_tdata[0], req_tdata[13:1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{16'd2240, 16'd4064, 14'd1000, 8'd3};
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_FULL: cfg_ff.full_distance_tenths <= csr_wdata;
            REG_EMPTY: cfg_ff.empty_distance_tenths <= csr_wdata;
            REG_REFILL: cfg_ff.refill_delta <= csr_wdata[13:0];
            REG_LIMIT: cfg_ff.fault_limit <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   lalf_front u_front (
      .clock(clock), .reset(reset), .in_valid(req_tvalid), .in_ready(req_tready),
      .in_item(in_item), .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
   );

   lalf_back u_back (
      .clock(clock), .reset(reset), .cfg(cfg_ff), .q_valid(q_valid),
      .q_item(q_item), .q_pop(q_pop), .ev_valid(rsp_tvalid), .ev(ev),
      .ev_ready(rsp_tready)
   );

   assign rsp_tdata = {6'd0, ev.event_distance, ev.level_hundredths, ev.threshold_level};
   assign rsp_tuser = ev.event_kind;
   assign rsp_tlast = ev.last_event;

   a_fault_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == EV_FAULT || rsp_tuser == EV_RECOVER) |-> rsp_tlast)
      else $error("fault or recovery item not last");
   a_thr_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != EV_THRESHOLD |-> rsp_tdata[6:0] == 7'd0)
      else $error("threshold level set on other kind");
   a_level_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[20:7] <= LEVEL_FULL)
      else $error("level out of range");
endmodule
